### design/oaht_pkg.sv
package oaht_pkg;

   localparam int KEY_W = 31;
   localparam int VER_W = 7;
   localparam int SIZE_W = 7;
   localparam int SLOT_W = 6;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;
   localparam int DEF_MAX_SLOTS = 64;
   localparam int MAX_RESULTS = 64;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [KEY_W-1:0] PROBE_STEP = 31'd37;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [1:0] SLOT_FREE = 2'd0;
   localparam logic [1:0] SLOT_BUSY = 2'd1;
   localparam logic [1:0] SLOT_DELETED = 2'd2;

   typedef struct packed {
      logic clr;
      logic accept;
      logic div_step;
      logic start;
      logic rd;
      logic eval_go;
      logic flush_go;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic is_ins;
      logic is_bad;
      logic ins_full;
      logic ins_take;
      logic walk_end;
      logic need_out;
      logic out_free;
   } stat_type;

endpackage

### design/oaht_ifs.sv
interface oaht_req_if;
   logic valid;
   logic ready;
   logic [oaht_pkg::MODE_W-1:0] mode;
   logic [oaht_pkg::KEY_W-1:0] key;
   logic [oaht_pkg::VER_W-1:0] version;
   logic [oaht_pkg::KEY_W-1:0] payload;
   modport source (output valid, mode, key, version, payload, input ready);
   modport sink (input valid, mode, key, version, payload, output ready);
endinterface

interface oaht_rsp_if;
   logic valid;
   logic ready;
   logic [oaht_pkg::STAT_W-1:0] status;
   logic [oaht_pkg::SLOT_W-1:0] slot;
   logic [oaht_pkg::KEY_W-1:0] found_key;
   logic [oaht_pkg::KEY_W-1:0] found_payload;
   logic [oaht_pkg::VER_W-1:0] match_version;
   logic last;
   modport source (output valid, status, slot, found_key, found_payload, match_version, last,
                   input ready);
   modport sink (input valid, status, slot, found_key, found_payload, match_version, last,
                 output ready);
endinterface

interface oaht_csr_if;
   logic valid;
   logic ready;
   logic [oaht_pkg::SIZE_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### design/open_address_hash_table_top.sv
// channel  dir  handshake      payload
// req      in   valid/ready    mode, key, version, payload
// rsp      out  valid/ready    status, slot, found_key, found_payload, match_version, last
// csr      in   valid/ready    data (table size, always ready)
//
// one item at a time: accept, then a bitwise key/step modulo pass, then setup,
// then per probe a slot memory read and then an evaluate, then a final result;
// an item with an unused mode ends at setup and gives no result
// after reset a clearing pass sets every slot free; no item is taken then
// a stalled rsp holds the walk whenever a result must enter a still full output register
module open_address_hash_table_top #(
   parameter int MAX_SLOTS = oaht_pkg::DEF_MAX_SLOTS
) (
   input logic        clock,
   input logic        reset,
   oaht_req_if.sink   req,
   oaht_rsp_if.source rsp,
   oaht_csr_if.sink   csr
);

   oaht_pkg::cmd_type  cmd;
   oaht_pkg::stat_type stat;
   logic req_ready;

   assign req.ready = req_ready;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   oaht_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req.mode),
      .req_key     (req.key),
      .req_version (req.version),
      .req_payload (req.payload),
      .rsp         (rsp),
      .csr         (csr)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("item taken while a walk is in progress");

   a_not_found_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == oaht_pkg::ST_NOT_FOUND |-> rsp.last && rsp.match_version == '0)
      else $error("not found result is not a lone final item");

   a_full_shape: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == oaht_pkg::ST_FULL |-> rsp.last && rsp.slot == '0)
      else $error("table full result malformed");

endmodule

### design/oaht_ctrl.sv
module oaht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  oaht_pkg::stat_type  stat,
   output oaht_pkg::cmd_type   cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_DIV = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;
   localparam logic [2:0] S_EVAL = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            priority if (stat.is_bad) state_in = S_IDLE;
            else if (stat.is_ins && stat.ins_full) state_in = S_FLUSH;
            else state_in = S_READ;
         end
         S_READ: begin
            cmd.rd = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!stat.need_out || stat.out_free) begin
               cmd.eval_go = 1'b1;
               state_in = (stat.ins_take || stat.walk_end) ? S_FLUSH : S_READ;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush_go = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule

### design/oaht_dp.sv
module oaht_dp #(
   parameter int MAX_SLOTS = oaht_pkg::DEF_MAX_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  oaht_pkg::cmd_type                 cmd,
   output oaht_pkg::stat_type                stat,
   input  logic [oaht_pkg::MODE_W-1:0]       req_mode,
   input  logic [oaht_pkg::KEY_W-1:0]        req_key,
   input  logic [oaht_pkg::VER_W-1:0]        req_version,
   input  logic [oaht_pkg::KEY_W-1:0]        req_payload,
   oaht_rsp_if.source                        rsp,
   oaht_csr_if.sink                          csr
);

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int CW = (SW > oaht_pkg::SIZE_W) ? SW : oaht_pkg::SIZE_W;
   localparam int KW = oaht_pkg::KEY_W;
   localparam int VW = oaht_pkg::VER_W;

   logic [1:0] st_mem [MAX_SLOTS];
   logic [KW-1:0] key_mem [MAX_SLOTS];
   logic [KW-1:0] pay_mem [MAX_SLOTS];

   logic [oaht_pkg::SIZE_W-1:0] tsize_ff, tsize_in;
   logic [oaht_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [KW-1:0] key_ff, key_in, pay_ff, pay_in;
   logic [VW-1:0] ver_ff, ver_in;
   logic [SW-1:0] size_ff, size_in;
   logic [KW-1:0] kshift_ff, kshift_in, sshift_ff, sshift_in;
   logic [SW-1:0] remk_ff, remk_in, rems_ff, rems_in;
   logic [4:0] dcnt_ff, dcnt_in;
   logic [IW-1:0] pos_ff, pos_in, clr_ff, clr_in;
   logic [SW-1:0] n_ff, n_in, busy_ff, busy_in;
   logic [VW-1:0] seen_ff, seen_in, cnt_ff, cnt_in;
   logic [1:0] strd_ff;
   logic [KW-1:0] keyrd_ff, payrd_ff;
   logic pend_v_ff, pend_v_in;
   logic [oaht_pkg::STAT_W-1:0] pst_ff, pst_in;
   logic [IW-1:0] pslot_ff, pslot_in;
   logic [KW-1:0] pkey_ff, pkey_in, ppay_ff, ppay_in;
   logic [VW-1:0] pver_ff, pver_in;
   logic rv_ff, rv_in, rl_ff, rl_in;
   logic [oaht_pkg::STAT_W-1:0] rst_ff, rst_in;
   logic [IW-1:0] rslot_ff, rslot_in;
   logic [KW-1:0] rkey_ff, rkey_in, rpay_ff, rpay_in;
   logic [VW-1:0] rver_ff, rver_in;

   logic [CW-1:0] ts_x, sz_x;
   logic [SW:0] trial_k, trial_s, psum, nsum;
   logic is_ins, is_srch, is_del, lookup, take, hit, emit, last_probe, out_free, push;
   logic [VW-1:0] seen_nx;
   logic [7:0] cnt_nx;
   logic [IW+5:0] slot_wide;

   assign csr.ready = 1'b1;

   assign is_ins = (mode_ff == oaht_pkg::MODE_INSERT);
   assign is_srch = (mode_ff == oaht_pkg::MODE_SEARCH);
   assign is_del = (mode_ff == oaht_pkg::MODE_DELETE);
   assign lookup = is_srch || is_del;
   assign take = (strd_ff != oaht_pkg::SLOT_BUSY);
   assign hit = (strd_ff == oaht_pkg::SLOT_BUSY) && (keyrd_ff == key_ff);
   assign seen_nx = seen_ff + VW'(1);
   assign cnt_nx = 8'(cnt_ff) + 8'd1;
   assign emit = lookup && hit && (is_srch || ver_ff == '0 || ver_ff == seen_nx);
   assign nsum = (SW+1)'(n_ff) + (SW+1)'(1);
   assign last_probe = nsum >= (SW+1)'(size_ff);
   assign out_free = !rv_ff || rsp.ready;
   assign push = cmd.eval_go && emit && pend_v_ff;
   assign ts_x = CW'(tsize_ff);
   assign sz_x = (ts_x == '0) ? CW'(1) : ((ts_x > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : ts_x);
   assign trial_k = {remk_ff, kshift_ff[KW-1]};
   assign trial_s = {rems_ff, sshift_ff[KW-1]};
   assign psum = (SW+1)'(pos_ff) + (SW+1)'(rems_ff);

   always_comb begin
      stat.clr_last = (clr_ff == IW'(MAX_SLOTS - 1));
      stat.div_last = (dcnt_ff == 5'(KW - 1));
      stat.is_ins = is_ins;
      stat.is_bad = !is_ins && !lookup;
      stat.ins_full = busy_ff >= size_ff;
      stat.ins_take = is_ins && take;
      stat.walk_end = is_ins ? last_probe
         : ((strd_ff == oaht_pkg::SLOT_FREE) || last_probe
            || (emit && ((is_del && ver_ff != '0) || cnt_nx >= 8'(oaht_pkg::MAX_RESULTS))));
      stat.need_out = emit && pend_v_ff;
      stat.out_free = out_free;
   end

   always_comb begin
      tsize_in = (csr.valid) ? csr.data : tsize_ff;
      mode_in = mode_ff; key_in = key_ff; pay_in = pay_ff; ver_in = ver_ff;
      size_in = size_ff; kshift_in = kshift_ff; sshift_in = sshift_ff;
      remk_in = remk_ff; rems_in = rems_ff; dcnt_in = dcnt_ff;
      pos_in = pos_ff; n_in = n_ff; seen_in = seen_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; clr_in = clr_ff;
      pend_v_in = pend_v_ff; pst_in = pst_ff; pslot_in = pslot_ff;
      pkey_in = pkey_ff; ppay_in = ppay_ff; pver_in = pver_ff;
      rv_in = rv_ff && !rsp.ready; rl_in = rl_ff; rst_in = rst_ff; rslot_in = rslot_ff;
      rkey_in = rkey_ff; rpay_in = rpay_ff; rver_in = rver_ff;
      if (cmd.clr) clr_in = clr_ff + IW'(1);
      if (cmd.accept) begin
         mode_in = req_mode; key_in = req_key; pay_in = req_payload; ver_in = req_version;
         size_in = SW'(sz_x);
         kshift_in = req_key; sshift_in = oaht_pkg::PROBE_STEP;
         remk_in = '0; rems_in = '0; dcnt_in = '0;
      end
      if (cmd.div_step) begin
         remk_in = (trial_k >= (SW+1)'(size_ff)) ? SW'(trial_k - (SW+1)'(size_ff))
                                                 : SW'(trial_k);
         rems_in = (trial_s >= (SW+1)'(size_ff)) ? SW'(trial_s - (SW+1)'(size_ff))
                                                 : SW'(trial_s);
         kshift_in = {kshift_ff[KW-2:0], 1'b0};
         sshift_in = {sshift_ff[KW-2:0], 1'b0};
         dcnt_in = dcnt_ff + 5'd1;
      end
      if (cmd.start) begin
         pos_in = IW'(remk_ff); n_in = '0; seen_in = '0; cnt_in = '0; pend_v_in = 1'b0;
      end
      if (cmd.eval_go) begin
         if (hit) seen_in = seen_nx;
         if (is_ins && take) begin
            busy_in = busy_ff + SW'(1);
            pend_v_in = 1'b1; pst_in = oaht_pkg::ST_OK; pslot_in = pos_ff;
            pkey_in = key_ff; ppay_in = pay_ff; pver_in = '0;
         end
         if (emit) begin
            cnt_in = VW'(cnt_nx);
            if (is_del && busy_ff != '0) busy_in = busy_ff - SW'(1);
            pend_v_in = 1'b1; pst_in = oaht_pkg::ST_OK; pslot_in = pos_ff;
            pkey_in = keyrd_ff; ppay_in = payrd_ff; pver_in = seen_nx;
         end
         pos_in = (psum >= (SW+1)'(size_ff)) ? IW'(psum - (SW+1)'(size_ff)) : IW'(psum);
         n_in = SW'(nsum);
      end
      if (push) begin
         rv_in = 1'b1; rl_in = 1'b0; rst_in = pst_ff; rslot_in = pslot_ff;
         rkey_in = pkey_ff; rpay_in = ppay_ff; rver_in = pver_ff;
      end
      if (cmd.flush_go) begin
         rv_in = 1'b1; rl_in = 1'b1;
         if (pend_v_ff) begin
            rst_in = pst_ff; rslot_in = pslot_ff; rkey_in = pkey_ff;
            rpay_in = ppay_ff; rver_in = pver_ff;
         end else begin
            rst_in = is_ins ? oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
            rslot_in = '0; rkey_in = '0; rpay_in = '0; rver_in = '0;
         end
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= oaht_pkg::SIZE_RESET;
         busy_ff <= '0;
         clr_ff <= '0;
         pend_v_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         tsize_ff <= tsize_in;
         busy_ff <= busy_in;
         clr_ff <= clr_in;
         pend_v_ff <= pend_v_in;
         rv_ff <= rv_in;
      end
      mode_ff <= mode_in; key_ff <= key_in; pay_ff <= pay_in; ver_ff <= ver_in;
      size_ff <= size_in; kshift_ff <= kshift_in; sshift_ff <= sshift_in;
      remk_ff <= remk_in; rems_ff <= rems_in; dcnt_ff <= dcnt_in;
      pos_ff <= pos_in; n_ff <= n_in; seen_ff <= seen_in; cnt_ff <= cnt_in;
      pst_ff <= pst_in; pslot_ff <= pslot_in; pkey_ff <= pkey_in;
      ppay_ff <= ppay_in; pver_ff <= pver_in;
      rl_ff <= rl_in; rst_ff <= rst_in; rslot_ff <= rslot_in;
      rkey_ff <= rkey_in; rpay_ff <= rpay_in; rver_ff <= rver_in;
   end

   // slot state memory
   always_ff @(posedge clock) begin
      if (cmd.clr) st_mem[clr_ff] <= oaht_pkg::SLOT_FREE;
      else if (cmd.eval_go && is_ins && take) st_mem[pos_ff] <= oaht_pkg::SLOT_BUSY;
      else if (cmd.eval_go && emit && is_del) st_mem[pos_ff] <= oaht_pkg::SLOT_DELETED;
      if (cmd.rd) strd_ff <= st_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_go && is_ins && take) begin
         key_mem[pos_ff] <= key_ff;
         pay_mem[pos_ff] <= pay_ff;
      end
      if (cmd.rd) begin
         keyrd_ff <= key_mem[pos_ff];
         payrd_ff <= pay_mem[pos_ff];
      end
   end

   assign slot_wide = {6'd0, rslot_ff};
   assign rsp.valid = rv_ff;
   assign rsp.status = rst_ff;
   assign rsp.slot = slot_wide[5:0];
   assign rsp.found_key = rkey_ff;
   assign rsp.found_payload = rpay_ff;
   assign rsp.match_version = rver_ff;
   assign rsp.last = rl_ff;

endmodule

### dv/oaht_tb_ifs.sv
interface oaht_tb_clk_if;
   logic clock;
   logic reset;
endinterface

### dv/open_address_hash_table_top_tb.sv
module open_address_hash_table_top_tb;

   localparam logic [oaht_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [oaht_pkg::STAT_W-1:0] status;
      logic [oaht_pkg::SLOT_W-1:0] slot;
      logic [oaht_pkg::KEY_W-1:0]  found_key;
      logic [oaht_pkg::KEY_W-1:0]  found_payload;
      logic [oaht_pkg::VER_W-1:0]  match_version;
      logic                        last;
   } outcome_type;

   oaht_tb_clk_if sys ();
   oaht_req_if req ();
   oaht_rsp_if rsp ();
   oaht_csr_if csr ();

   open_address_hash_table_top i_dut (
      .clock(sys.clock), .reset(sys.reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // own copy of the table
   logic [oaht_pkg::SIZE_W-1:0] size_reg;
   logic [1:0]                  tbl_state [oaht_pkg::DEF_MAX_SLOTS];
   logic [oaht_pkg::KEY_W-1:0]  tbl_key [oaht_pkg::DEF_MAX_SLOTS];
   logic [oaht_pkg::KEY_W-1:0]  tbl_payload [oaht_pkg::DEF_MAX_SLOTS];
   int unsigned                 occupied;
   outcome_type                 pending [$];
   int                          errors = 0;
   int                          send_idle_pct;
   int                          recv_stall_pct;
   logic                        hold_on = 1'b0;
   logic [oaht_pkg::KEY_W-1:0]  used_keys [$];

   always begin
      sys.clock = 1'b0;
      #5;
      sys.clock = 1'b1;
      #5;
   end

   function automatic outcome_type mk(logic [oaht_pkg::STAT_W-1:0] st, int unsigned s,
                                      logic [oaht_pkg::KEY_W-1:0] k,
                                      logic [oaht_pkg::KEY_W-1:0] p, int unsigned v, logic l);
      outcome_type o;
      o.status = st;
      o.slot = s[oaht_pkg::SLOT_W-1:0];
      o.found_key = k;
      o.found_payload = p;
      o.match_version = v[oaht_pkg::VER_W-1:0];
      o.last = l;
      return o;
   endfunction

   task automatic predict_table_op(logic [oaht_pkg::MODE_W-1:0] mode,
                                   logic [oaht_pkg::KEY_W-1:0] key,
                                   logic [oaht_pkg::VER_W-1:0] ver,
                                   logic [oaht_pkg::KEY_W-1:0] pay);
      int unsigned sz;
      int unsigned pos;
      int unsigned seen;
      int          cnt;
      bit          done;
      sz = (size_reg == 0) ? 1 : (size_reg > oaht_pkg::DEF_MAX_SLOTS) ? oaht_pkg::DEF_MAX_SLOTS
                                                                     : size_reg;
      pos = key % sz;
      seen = 0;
      cnt = 0;
      done = 0;
      if (mode == oaht_pkg::MODE_INSERT) begin
         if (occupied < sz) begin
            for (int n = 0; n < sz && !done; n++) begin
               if (tbl_state[pos] != oaht_pkg::SLOT_BUSY) begin
                  tbl_state[pos] = oaht_pkg::SLOT_BUSY;
                  tbl_key[pos] = key;
                  tbl_payload[pos] = pay;
                  occupied++;
                  pending.push_back(mk(oaht_pkg::ST_OK, pos, key, pay, 0, 1'b1));
                  done = 1;
               end else begin
                  pos = (pos + 37) % sz;
               end
            end
         end
         if (!done) pending.push_back(mk(oaht_pkg::ST_FULL, 0, '0, '0, 0, 1'b1));
      end else if (mode == oaht_pkg::MODE_SEARCH || mode == oaht_pkg::MODE_DELETE) begin
         for (int n = 0; n < sz && tbl_state[pos] != oaht_pkg::SLOT_FREE && !done; n++) begin
            if (tbl_state[pos] == oaht_pkg::SLOT_BUSY && tbl_key[pos] == key) begin
               seen++;
               if (mode == oaht_pkg::MODE_SEARCH) begin
                  pending.push_back(mk(oaht_pkg::ST_OK, pos, key, tbl_payload[pos], seen, 1'b0));
                  cnt++;
               end else if (ver == 0 || ver == seen) begin
                  pending.push_back(mk(oaht_pkg::ST_OK, pos, key, tbl_payload[pos], seen, 1'b0));
                  cnt++;
                  tbl_state[pos] = oaht_pkg::SLOT_DELETED;
                  if (occupied > 0) occupied--;
                  if (ver != 0) done = 1;
               end
               if (cnt >= oaht_pkg::MAX_RESULTS) done = 1;
            end
            pos = (pos + 37) % sz;
         end
         if (cnt == 0) pending.push_back(mk(oaht_pkg::ST_NOT_FOUND, 0, '0, '0, 0, 1'b1));
         else pending[pending.size()-1].last = 1'b1;
      end
   endtask

   task automatic send_item(logic [oaht_pkg::MODE_W-1:0] mode, logic [oaht_pkg::KEY_W-1:0] key,
                            logic [oaht_pkg::VER_W-1:0] ver, logic [oaht_pkg::KEY_W-1:0] pay);
      bit idle;
      idle = ($urandom_range(99) < send_idle_pct);
      if (idle) req.valid <= 1'b0;
      while (idle) begin
         @(posedge sys.clock);
         idle = ($urandom_range(99) < send_idle_pct);
      end
      req.valid <= 1'b1;
      req.mode <= mode;
      req.key <= key;
      req.version <= ver;
      req.payload <= pay;
      do @(posedge sys.clock); while (!req.ready);
      predict_table_op(mode, key, ver, pay);
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      while (pending.size() != 0) @(posedge sys.clock);
      repeat (200) @(posedge sys.clock);
   endtask

   task automatic write_size(logic [oaht_pkg::SIZE_W-1:0] value);
      drain();
      csr.valid <= 1'b1;
      csr.data <= value;
      do @(posedge sys.clock); while (!csr.ready);
      size_reg = value;
      csr.valid <= 1'b0;
   endtask

   // result checker
   always @(posedge sys.clock) begin : check_results
      outcome_type got;
      outcome_type want;
      if (!sys.reset && rsp.valid && rsp.ready) begin
         got = '{rsp.status, rsp.slot, rsp.found_key, rsp.found_payload, rsp.match_version,
                 rsp.last};
         if (pending.size() == 0) begin
            $display("%0t unexpected item %p", $time, got);
            errors++;
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               $display("%0t mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(posedge sys.clock) begin
      rsp.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [oaht_pkg::KEY_W-1:0] pick_key();
      logic [31:0] r;
      if (used_keys.size() != 0 && $urandom_range(3) != 0)
         return used_keys[$urandom_range(used_keys.size()-1)];
      r = $urandom();
      if ($urandom_range(7) == 0) return r[oaht_pkg::KEY_W-1:0];
      return oaht_pkg::KEY_W'($urandom_range(300));
   endfunction

   task automatic test_directed;
      write_size(7'd64);
      send_item(oaht_pkg::MODE_INSERT, 31'h7fffffff, 7'd0, 31'h7fffffff);
      send_item(oaht_pkg::MODE_INSERT, 31'd0, 7'd127, 31'd0);
      send_item(oaht_pkg::MODE_INSERT, 31'd64, 7'd0, 31'h55555555);
      send_item(oaht_pkg::MODE_INSERT, 31'd64, 7'd0, 31'h2aaaaaaa);
      send_item(oaht_pkg::MODE_SEARCH, 31'd64, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_SEARCH, 31'd5, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_DELETE, 31'd64, 7'd5, 31'd0);
      send_item(oaht_pkg::MODE_DELETE, 31'd64, 7'd2, 31'd0);
      send_item(MODE_UNUSED, 31'd64, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_SEARCH, 31'd64, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_DELETE, 31'd0, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_INSERT, 31'd0, 7'd0, 31'd9);
      send_item(oaht_pkg::MODE_SEARCH, 31'h7fffffff, 7'd64, 31'd0);
   endtask

   task automatic test_small_sizes;
      write_size(7'd0);
      send_item(oaht_pkg::MODE_INSERT, 31'd3, 7'd0, 31'd1);
      send_item(oaht_pkg::MODE_INSERT, 31'd4, 7'd0, 31'd2);
      send_item(oaht_pkg::MODE_SEARCH, 31'd3, 7'd0, 31'd0);
      write_size(7'd127);
      send_item(oaht_pkg::MODE_SEARCH, 31'h7fffffff, 7'd0, 31'd0);
      write_size(7'd37);
      for (int i = 0; i < 5; i++)
         send_item(oaht_pkg::MODE_INSERT, 31'd74, 7'd0, oaht_pkg::KEY_W'(i));
      send_item(oaht_pkg::MODE_SEARCH, 31'd74, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_DELETE, 31'd74, 7'd0, 31'd0);
   endtask

   task automatic test_many_matches;
      write_size(7'd64);
      for (int i = 0; i < 62; i++)
         send_item(oaht_pkg::MODE_INSERT, 31'd11, 7'd0, oaht_pkg::KEY_W'(i));
      send_item(oaht_pkg::MODE_SEARCH, 31'd11, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_DELETE, 31'd11, 7'd0, 31'd0);
      send_item(oaht_pkg::MODE_DELETE, 31'd11, 7'd0, 31'd0);
   endtask

   task automatic random_phase(int sidle, int rstall, int count,
                               logic [oaht_pkg::SIZE_W-1:0] sz);
      logic [oaht_pkg::MODE_W-1:0] m;
      logic [oaht_pkg::KEY_W-1:0]  k;
      write_size(sz);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      for (int i = 0; i < count; i++) begin
         m = $urandom_range(15) == 0 ? MODE_UNUSED : oaht_pkg::MODE_W'($urandom_range(2));
         k = pick_key();
         if (m == oaht_pkg::MODE_INSERT) used_keys.push_back(k);
         send_item(m, k, $urandom_range(3) == 0 ? oaht_pkg::VER_W'($urandom_range(127))
                                                : oaht_pkg::VER_W'($urandom_range(3)),
                   oaht_pkg::KEY_W'($urandom()));
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure;
      write_size(7'd16);
      // long receiver hold, counted in its own process
      fork
         begin
            hold_on <= 1'b1;
            repeat (600) @(posedge sys.clock);
            hold_on <= 1'b0;
         end
      join_none
      for (int i = 0; i < 6; i++)
         send_item(oaht_pkg::MODE_INSERT, 31'd5, 7'd0, oaht_pkg::KEY_W'(i));
   endtask

   initial begin
      sys.reset = 1'b1;
      req.valid = 1'b0;
      req.mode = '0;
      req.key = '0;
      req.version = '0;
      req.payload = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      size_reg = oaht_pkg::SIZE_RESET;
      occupied = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < oaht_pkg::DEF_MAX_SLOTS; i++) tbl_state[i] = oaht_pkg::SLOT_FREE;
      repeat (2) @(posedge sys.clock);
      sys.reset <= 1'b0;
      test_directed();
      test_small_sizes();
      test_many_matches();
      test_backpressure();
      random_phase(0, 0, 5, 7'd64);
      random_phase(81, 0, 5, 7'd20);
      random_phase(0, 81, 5, 7'd1);
      random_phase(13, 13, 5, 7'd64);
      drain();
      if (errors == 0 && pending.size() == 0) begin
         $display("PASS open_address_hash_table_top");
      end else begin
         $display("FAIL open_address_hash_table_top");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL open_address_hash_table_top");
      $finish;
   end
endmodule
